FILE: rtl/core/qre_pkg.sv
// Shared types, constants and helper functions of the quaternion to Euler converter.
// No dependencies; the front end, the CORDIC cell and the top level import this package.
`default_nettype none
package qre_pkg;

    // Width of the CORDIC x/y datapath, set by the 16-bit quaternion fields.
    localparam int XYW = 38;
    // Width of the angle accumulator, degrees in Q16.
    localparam int ZW = 26;
    localparam int ATAN_LEN = 24;
    localparam int DEG90_Q16 = 5898240;
    localparam int DEG180_Q7 = 23040;
    localparam int DEG90_Q7 = 11520;
    localparam int Q7_ROUND = 256;
    localparam int Q7_SHIFT = 9;

    // Configuration register indexes.
    localparam logic [7:0] REG_ACCEPTED_CHANNEL = 8'd0;
    localparam logic [7:0] REG_ACCEPTED_REPORT = 8'd1;
    localparam logic [7:0] RST_ACCEPTED_CHANNEL = 8'd3;
    localparam logic [7:0] RST_ACCEPTED_REPORT = 8'd5;

    typedef logic signed [XYW-1:0] xy_t;
    typedef logic signed [ZW-1:0] ang_t;

    typedef struct packed {
        logic vld;
        logic match;
        logic stream;
    } qre_ctl_t;

    typedef struct packed {
        xy_t  x;
        xy_t  y;
        ang_t z;
    } qre_vec_t;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
        logic               streaming;
        logic               angles_valid;
    } qre_res_t;

    // round(atan(2^-n) in degrees * 65536)
    localparam ang_t ATAN_TAB [ATAN_LEN] = '{
        ang_t'(2949120), ang_t'(1740967), ang_t'(919879), ang_t'(466945),
        ang_t'(234379), ang_t'(117304), ang_t'(58666), ang_t'(29335),
        ang_t'(14668), ang_t'(7334), ang_t'(3667), ang_t'(1833),
        ang_t'(917), ang_t'(458), ang_t'(229), ang_t'(115),
        ang_t'(57), ang_t'(29), ang_t'(14), ang_t'(7),
        ang_t'(4), ang_t'(2), ang_t'(1), ang_t'(0)
    };

    // Turn a left half-plane vector by 90 degrees toward the positive x axis.
    function automatic qre_vec_t qre_prerot(input xy_t x, input xy_t y);
        qre_vec_t res;
        res.x = x;
        res.y = y;
        res.z = '0;
        if (x < 0) begin
            if (y >= 0) begin
                res.x = y;
                res.y = -x;
                res.z = ang_t'(DEG90_Q16);
            end else begin
                res.x = -y;
                res.y = x;
                res.z = -ang_t'(DEG90_Q16);
            end
        end
        return res;
    endfunction

    // Q16 degrees to Q7 with round half up, then clamp to +-lim.
    function automatic ang_t qre_to_q7(input ang_t z, input ang_t lim);
        ang_t v;
        v = (z + ang_t'(Q7_ROUND)) >>> Q7_SHIFT;
        if (v > lim) begin
            v = lim;
        end
        if (v < -lim) begin
            v = -lim;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/qre_front.sv
// Front end: report match, sticky streaming flag, quaternion products and asin radicand.
// Depends on qre_pkg.
`default_nettype none
module qre_front #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_vld,
    input  wire logic [7:0]                channel,
    input  wire logic [7:0]                report_id,
    input  wire logic signed [15:0]        quat_i,
    input  wire logic signed [15:0]        quat_j,
    input  wire logic signed [15:0]        quat_k,
    input  wire logic signed [15:0]        quat_real,
    input  wire logic [7:0]                acc_channel,
    input  wire logic [7:0]                acc_report,
    output qre_pkg::qre_ctl_t              ctl_out,
    output qre_pkg::xy_t                   roll_x,
    output qre_pkg::xy_t                   roll_y,
    output qre_pkg::xy_t                   yaw_x,
    output qre_pkg::xy_t                   yaw_y,
    output qre_pkg::xy_t                   s_out,
    output logic [4*QUAT_FRAC_BITS:0]      rad_out
);
    import qre_pkg::*;

    localparam int F = QUAT_FRAC_BITS;
    localparam int RW = 4 * F + 1;
    localparam int L = F + 1;
    localparam xy_t ONE = xy_t'(64'd1 << (2 * F));

    logic stream_reg;
    logic match;
    qre_ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;

    logic signed [15:0] qi_reg, qj_reg, qk_reg, qr_reg;
    logic signed [31:0] p_ri_reg, p_jk_reg, p_ii_reg, p_jj_reg;
    logic signed [31:0] p_rk_reg, p_ij_reg, p_kk_reg, p_rj_reg, p_ki_reg;

    xy_t roll_x3_reg, roll_y3_reg, yaw_x3_reg, yaw_y3_reg, s3_reg;
    xy_t roll_x4_reg, roll_y4_reg, yaw_x4_reg, yaw_y4_reg, s4_reg;
    xy_t roll_x5_reg, roll_y5_reg, yaw_x5_reg, yaw_y5_reg, s5_reg;
    logic [2*F:0] smag3_reg;
    logic [2*F-1:0] hh_reg;
    logic [2*F:0] hl_reg;
    logic [2*L-1:0] ll_reg;
    logic [RW-1:0] rad5_reg;

    xy_t s_raw, s_sat, s_abs, ry, rx, yy, yx;
    logic [F-1:0] s_hi;
    logic [L-1:0] s_lo;
    logic [RW-1:0] sq;

    assign match = (channel == acc_channel) && (report_id == acc_report);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stream_reg <= 1'b0;
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end else if (en) begin
            if (in_vld && match) begin
                stream_reg <= 1'b1;
            end
            ctl1_reg.vld <= in_vld;
            ctl1_reg.match <= match;
            ctl1_reg.stream <= stream_reg | (in_vld & match);
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
        end
    end

    always_comb begin
        ry = (xy_t'(p_ri_reg) + xy_t'(p_jk_reg)) <<< 1;
        rx = ONE - ((xy_t'(p_ii_reg) + xy_t'(p_jj_reg)) <<< 1);
        yy = (xy_t'(p_rk_reg) + xy_t'(p_ij_reg)) <<< 1;
        yx = ONE - ((xy_t'(p_jj_reg) + xy_t'(p_kk_reg)) <<< 1);
        s_raw = (xy_t'(p_rj_reg) - xy_t'(p_ki_reg)) <<< 1;
        s_sat = s_raw;
        if (s_raw > ONE) begin
            s_sat = ONE;
        end
        if (s_raw < -ONE) begin
            s_sat = -ONE;
        end
        s_abs = (s_sat < 0) ? -s_sat : s_sat;
    end

    assign s_hi = smag3_reg[2*F:L];
    assign s_lo = smag3_reg[L-1:0];
    assign sq = (RW'(hh_reg) << (2 * L)) + (RW'(hl_reg) << (L + 1)) + RW'(ll_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            qi_reg <= quat_i;
            qj_reg <= quat_j;
            qk_reg <= quat_k;
            qr_reg <= quat_real;

            p_ri_reg <= qr_reg * qi_reg;
            p_jk_reg <= qj_reg * qk_reg;
            p_ii_reg <= qi_reg * qi_reg;
            p_jj_reg <= qj_reg * qj_reg;
            p_rk_reg <= qr_reg * qk_reg;
            p_ij_reg <= qi_reg * qj_reg;
            p_kk_reg <= qk_reg * qk_reg;
            p_rj_reg <= qr_reg * qj_reg;
            p_ki_reg <= qk_reg * qi_reg;

            roll_x3_reg <= rx;
            roll_y3_reg <= ry;
            yaw_x3_reg <= yx;
            yaw_y3_reg <= yy;
            s3_reg <= s_sat;
            smag3_reg <= s_abs[2*F:0];

            // split |s| so each partial product stays narrow
            hh_reg <= s_hi * s_hi;
            hl_reg <= s_hi * s_lo;
            ll_reg <= s_lo * s_lo;
            roll_x4_reg <= roll_x3_reg;
            roll_y4_reg <= roll_y3_reg;
            yaw_x4_reg <= yaw_x3_reg;
            yaw_y4_reg <= yaw_y3_reg;
            s4_reg <= s3_reg;

            rad5_reg <= (RW'(1) << (4 * F)) - sq;
            roll_x5_reg <= roll_x4_reg;
            roll_y5_reg <= roll_y4_reg;
            yaw_x5_reg <= yaw_x4_reg;
            yaw_y5_reg <= yaw_y4_reg;
            s5_reg <= s4_reg;
        end
    end

    assign ctl_out = ctl5_reg;
    assign roll_x = roll_x5_reg;
    assign roll_y = roll_y5_reg;
    assign yaw_x = yaw_x5_reg;
    assign yaw_y = yaw_y5_reg;
    assign s_out = s5_reg;
    assign rad_out = rad5_reg;

endmodule
`default_nettype wire

FILE: rtl/core/qre_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
// Depends on nothing beyond its parameters.
`default_nettype none
module qre_sqrt_cell #(
    parameter int QUAT_FRAC_BITS = 14,
    parameter int IDX = 0
) (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic [4*QUAT_FRAC_BITS:0] n_in,
    input  wire logic [4*QUAT_FRAC_BITS:0] r_in,
    output logic [4*QUAT_FRAC_BITS:0]      n_out,
    output logic [4*QUAT_FRAC_BITS:0]      r_out
);
    localparam int RW = 4 * QUAT_FRAC_BITS + 1;
    localparam logic [RW:0] BIT = (RW + 1)'(1) << (4 * QUAT_FRAC_BITS - 2 * IDX);

    logic [RW-1:0] n_reg, r_reg;
    logic [RW:0] trial;

    assign trial = {1'b0, r_in} + BIT;

    always_ff @(posedge aclk) begin
        if (en) begin
            if ({1'b0, n_in} >= trial) begin
                n_reg <= n_in - trial[RW-1:0];
                r_reg <= (r_in >> 1) + BIT[RW-1:0];
            end else begin
                n_reg <= n_in;
                r_reg <= r_in >> 1;
            end
        end
    end

    assign n_out = n_reg;
    assign r_out = r_reg;

endmodule
`default_nettype wire

FILE: rtl/core/qre_cordic_cell.sv
// One vectoring stage of the atan2 CORDIC chain.
// Depends on qre_pkg for the vector type and the arctangent table.
`default_nettype none
module qre_cordic_cell #(
    parameter int IDX = 0
) (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire qre_pkg::qre_vec_t  vec_in,
    output qre_pkg::qre_vec_t       vec_out
);
    import qre_pkg::*;

    qre_vec_t vec_reg;
    xy_t dx, dy;

    assign dx = vec_in.y >>> IDX;
    assign dy = vec_in.x >>> IDX;

    always_ff @(posedge aclk) begin
        if (en) begin
            // steer by the sign of y: y >= 0 rotates clockwise
            if (vec_in.y >= 0) begin
                vec_reg.x <= vec_in.x + dx;
                vec_reg.y <= vec_in.y - dy;
                vec_reg.z <= vec_in.z + ATAN_TAB[IDX];
            end else begin
                vec_reg.x <= vec_in.x - dx;
                vec_reg.y <= vec_in.y + dy;
                vec_reg.z <= vec_in.z - ATAN_TAB[IDX];
            end
        end
    end

    assign vec_out = vec_reg;

endmodule
`default_nettype wire

FILE: rtl/core/quaternion_report_to_euler.sv
// Path from input transfer to m_tvalid: front end, square-root cells, pre-rotation,
//   CORDIC cells, conversion register and output register.
// Throughput: one report per cycle while the skid slot is empty; the whole chain advances together.
// Reset (aresetn low, synchronous): clears pipeline valids, the output and skid slots,
//   the streaming flag, and loads accepted_channel = 3, accepted_report = 5.
`default_nettype none
module quaternion_report_to_euler #(
    parameter int CORDIC_STAGES = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] channel, [15:8] report_id, [31:16] quat_i, [47:32] quat_j,
    // [63:48] quat_k, [79:64] quat_real
    input  wire logic [79:0] s_tdata,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] angles_valid, [1] streaming, [17:2] roll_deg, [32:18] pitch_deg,
    // [48:33] yaw_deg, [55:49] zero
    output logic [55:0]      m_tdata,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import qre_pkg::*;

    localparam int F = QUAT_FRAC_BITS;
    localparam int RW = 4 * F + 1;
    localparam int SQN = 2 * F + 1;
    localparam int NS = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    // Configuration registers: always ready, a write is registered and lands on the next clock edge.
    logic [7:0] acc_channel_reg, acc_report_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_channel_reg <= RST_ACCEPTED_CHANNEL;
            acc_report_reg <= RST_ACCEPTED_REPORT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ACCEPTED_CHANNEL: acc_channel_reg <= cfg_data;
                REG_ACCEPTED_REPORT:  acc_report_reg <= cfg_data;
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // Pipeline enable comes from the skid slot alone, so ready never waits on
    // m_tready combinationally; an item leaving the chain always finds room.
    logic skid_vld_reg, out_vld_reg;
    qre_res_t skid_reg, out_reg;
    logic en;

    assign en = !skid_vld_reg;
    assign s_tready = en;

    // Front end: match, products, asin radicand.
    qre_ctl_t f_ctl;
    xy_t f_roll_x, f_roll_y, f_yaw_x, f_yaw_y, f_s;
    logic [RW-1:0] f_rad;

    qre_front #(
        .QUAT_FRAC_BITS(F)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .en(en),
        .in_vld(s_tvalid),
        .channel(s_tdata[7:0]),
        .report_id(s_tdata[15:8]),
        .quat_i(s_tdata[31:16]),
        .quat_j(s_tdata[47:32]),
        .quat_k(s_tdata[63:48]),
        .quat_real(s_tdata[79:64]),
        .acc_channel(acc_channel_reg),
        .acc_report(acc_report_reg),
        .ctl_out(f_ctl),
        .roll_x(f_roll_x),
        .roll_y(f_roll_y),
        .yaw_x(f_yaw_x),
        .yaw_y(f_yaw_y),
        .s_out(f_s),
        .rad_out(f_rad)
    );

    // Square-root chain: c = floor(sqrt(one^2 - s^2)), one result bit per cell.
    logic [RW-1:0] sq_n [SQN+1];
    logic [RW-1:0] sq_r [SQN+1];

    assign sq_n[0] = f_rad;
    assign sq_r[0] = '0;

    for (genvar k = 0; k < SQN; k++) begin : g_sqrt
        qre_sqrt_cell #(
            .QUAT_FRAC_BITS(F),
            .IDX(k)
        ) u_cell (
            .aclk(aclk),
            .en(en),
            .n_in(sq_n[k]),
            .r_in(sq_r[k]),
            .n_out(sq_n[k+1]),
            .r_out(sq_r[k+1])
        );
    end

    // Side data that rides along the square-root chain.
    qre_ctl_t sb_ctl_reg [SQN];
    xy_t sb_roll_x_reg [SQN];
    xy_t sb_roll_y_reg [SQN];
    xy_t sb_yaw_x_reg [SQN];
    xy_t sb_yaw_y_reg [SQN];
    xy_t sb_s_reg [SQN];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SQN; i++) begin
                sb_ctl_reg[i] <= '0;
            end
        end else if (en) begin
            sb_ctl_reg[0] <= f_ctl;
            for (int i = 1; i < SQN; i++) begin
                sb_ctl_reg[i] <= sb_ctl_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_roll_x_reg[0] <= f_roll_x;
            sb_roll_y_reg[0] <= f_roll_y;
            sb_yaw_x_reg[0] <= f_yaw_x;
            sb_yaw_y_reg[0] <= f_yaw_y;
            sb_s_reg[0] <= f_s;
            for (int i = 1; i < SQN; i++) begin
                sb_roll_x_reg[i] <= sb_roll_x_reg[i-1];
                sb_roll_y_reg[i] <= sb_roll_y_reg[i-1];
                sb_yaw_x_reg[i] <= sb_yaw_x_reg[i-1];
                sb_yaw_y_reg[i] <= sb_yaw_y_reg[i-1];
                sb_s_reg[i] <= sb_s_reg[i-1];
            end
        end
    end

    // Pre-rotation stage: fold the left half-plane and flag zero vectors.
    // Lane 0 is roll, lane 1 pitch, lane 2 yaw.
    xy_t c_val;
    xy_t pre_x [3];
    xy_t pre_y [3];
    qre_vec_t vec [3][NS+1];
    qre_vec_t pre_reg [3];
    logic [2:0] pre_zero_reg;
    qre_ctl_t pre_ctl_reg;

    assign c_val = xy_t'($signed({1'b0, sq_r[SQN][2*F:0]}));
    assign pre_x[0] = sb_roll_x_reg[SQN-1];
    assign pre_y[0] = sb_roll_y_reg[SQN-1];
    assign pre_x[1] = c_val;
    assign pre_y[1] = sb_s_reg[SQN-1];
    assign pre_x[2] = sb_yaw_x_reg[SQN-1];
    assign pre_y[2] = sb_yaw_y_reg[SQN-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_ctl_reg <= '0;
        end else if (en) begin
            pre_ctl_reg <= sb_ctl_reg[SQN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                pre_reg[a] <= qre_prerot(pre_x[a], pre_y[a]);
                pre_zero_reg[a] <= (pre_x[a] == 0) && (pre_y[a] == 0);
            end
        end
    end

    // Three CORDIC chains, one per angle.
    for (genvar a = 0; a < 3; a++) begin : g_lane
        assign vec[a][0] = pre_reg[a];
        for (genvar n = 0; n < NS; n++) begin : g_stage
            qre_cordic_cell #(
                .IDX(n)
            ) u_cell (
                .aclk(aclk),
                .en(en),
                .vec_in(vec[a][n]),
                .vec_out(vec[a][n+1])
            );
        end
    end

    qre_ctl_t cd_ctl_reg [NS];
    logic [2:0] cd_zero_reg [NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NS; i++) begin
                cd_ctl_reg[i] <= '0;
            end
        end else if (en) begin
            cd_ctl_reg[0] <= pre_ctl_reg;
            for (int i = 1; i < NS; i++) begin
                cd_ctl_reg[i] <= cd_ctl_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cd_zero_reg[0] <= pre_zero_reg;
            for (int i = 1; i < NS; i++) begin
                cd_zero_reg[i] <= cd_zero_reg[i-1];
            end
        end
    end

    // Conversion stage: Q16 to Q7, clamp, zero the fields of a non-matching report.
    qre_ctl_t last_ctl;
    ang_t z_fin [3];
    ang_t roll_q7, pitch_q7, yaw_q7;
    qre_res_t res_next;
    qre_res_t cv_reg;
    logic cv_vld_reg;

    assign last_ctl = cd_ctl_reg[NS-1];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            z_fin[a] = cd_zero_reg[NS-1][a] ? ang_t'(0) : vec[a][NS].z;
        end
        roll_q7 = qre_to_q7(z_fin[0], ang_t'(DEG180_Q7));
        pitch_q7 = qre_to_q7(z_fin[1], ang_t'(DEG90_Q7));
        yaw_q7 = qre_to_q7(z_fin[2], ang_t'(DEG180_Q7));
        res_next.angles_valid = last_ctl.match;
        res_next.streaming = last_ctl.stream;
        res_next.roll = last_ctl.match ? roll_q7[15:0] : '0;
        res_next.pitch = last_ctl.match ? pitch_q7[14:0] : '0;
        res_next.yaw = last_ctl.match ? yaw_q7[15:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_vld_reg <= 1'b0;
        end else if (en) begin
            cv_vld_reg <= last_ctl.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cv_reg <= res_next;
        end
    end

    // Output register with a skid slot behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_tready) begin
            // output slot frees up: refill from skid first, then from the chain
            if (skid_vld_reg) begin
                out_vld_reg <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg <= en && cv_vld_reg;
            end
        end else if (en && cv_vld_reg) begin
            // output stalled: hold the new result in the skid slot
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || m_tready) begin
            out_reg <= skid_vld_reg ? skid_reg : cv_reg;
        end else if (en && cv_vld_reg) begin
            skid_reg <= cv_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata = {7'd0, out_reg};

endmodule
`default_nettype wire

FILE: rtl/core/qre_checker.sv
// Port-level checks for quaternion_report_to_euler, attached with bind.
// Depends only on the top level's ports.
`default_nettype none
module qre_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a non-matching report carries zero angles
    a_nomatch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[55:2] == 54'd0)
        else $error("non-matching report with nonzero angles");

    // a matching report implies the streaming flag
    a_match_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("match without streaming flag");

    // a valid result directly after a transferred streaming result keeps the flag
    a_stream_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tdata[1] ##1 m_tvalid |-> m_tdata[1])
        else $error("streaming flag dropped");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind quaternion_report_to_euler qre_checker u_qre_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);
`default_nettype wire
